[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the compensation block.
// ----------------------------------------------------------------------------
// Each macro expects clk and rst to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define BPC_ASSERT_IMM(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequence must hold in the cycle after the antecedent.
`define BPC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/bpc_pkg.sv]
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the barometric pressure compensation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpc_pkg;

  // APB address width: six 32-bit registers at byte offsets 0 to 20.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Number of register stages in the arithmetic pipeline.
  localparam int STAGES = 10;

  typedef enum logic [2:0] {
    REG_C1 = 3'd0,
    REG_C2 = 3'd1,
    REG_C3 = 3'd2,
    REG_C4 = 3'd3,
    REG_C5 = 3'd4,
    REG_C6 = 3'd5
  } reg_idx_t;

  // Calibration words as seen by the datapath.
  typedef struct packed {
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] c3;
    logic [15:0] c4;
    logic [15:0] c5;
    logic [15:0] c6;
  } coef_t;

endpackage

[hdl/bpc_in_if.sv]
// ----------------------------------------------------------------------------
// bpc_in_if
// Valid/ready channel carrying one pair of raw conversions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] raw_pressure;
  logic [23:0] raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

[hdl/bpc_out_if.sv]
// ----------------------------------------------------------------------------
// bpc_out_if
// Valid/ready channel carrying one compensated pressure and temperature.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pressure;
  logic signed [31:0] temperature;

  modport source (output valid, output pressure, output temperature, input ready);
  modport sink   (input valid, input pressure, input temperature, output ready);
endinterface

[hdl/bpc_regs.sv]
// ----------------------------------------------------------------------------
// bpc_regs
// APB register file holding the six calibration words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpc_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0] paddr,
  input  logic [bpc_pkg::DATA_W-1:0] pwdata,
  output logic [bpc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output bpc_pkg::coef_t             coefs
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[bpc_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs <= '0;
    end else if (wr_en) begin
      case (idx)
        bpc_pkg::REG_C1: coefs.c1 <= pwdata[15:0];
        bpc_pkg::REG_C2: coefs.c2 <= pwdata[15:0];
        bpc_pkg::REG_C3: coefs.c3 <= pwdata[15:0];
        bpc_pkg::REG_C4: coefs.c4 <= pwdata[15:0];
        bpc_pkg::REG_C5: coefs.c5 <= pwdata[15:0];
        bpc_pkg::REG_C6: coefs.c6 <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bpc_pkg::REG_C1: prdata = {16'b0, coefs.c1};
      bpc_pkg::REG_C2: prdata = {16'b0, coefs.c2};
      bpc_pkg::REG_C3: prdata = {16'b0, coefs.c3};
      bpc_pkg::REG_C4: prdata = {16'b0, coefs.c4};
      bpc_pkg::REG_C5: prdata = {16'b0, coefs.c5};
      bpc_pkg::REG_C6: prdata = {16'b0, coefs.c6};
      default:         prdata = '0;
    endcase
  end

endmodule

[hdl/bpc_core.sv]
// ----------------------------------------------------------------------------
// bpc_core
// Ten-stage compensation pipeline with per-stage valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpc_core (
  input  logic           clk,
  input  logic           rst,
  input  bpc_pkg::coef_t coefs,
  bpc_in_if.sink         sample,
  bpc_out_if.source      result
);

  localparam int N = bpc_pkg::STAGES;

  logic [N-1:0] vld;
  logic [N-1:0] adv;

  // A stage takes new data when it is empty or its contents move on.
  always_comb begin
    adv[N-1] = !vld[N-1] || result.ready;
    for (int i = N - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= sample.valid;
      end
      for (int i = 1; i < N; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign sample.ready = adv[0];
  assign result.valid = vld[N-1];

  // Stage 1: temperature difference.
  logic        [23:0] d1_s1;
  logic signed [25:0] dt_s1;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      d1_s1 <= sample.raw_pressure;
      dt_s1 <= $signed({2'b0, sample.raw_temperature}) - $signed({2'b0, coefs.c5, 8'b0});
    end
  end

  // Stage 2: the three products with dT.
  logic        [23:0] d1_s2;
  logic signed [42:0] p6_s2;
  logic signed [42:0] p4_s2;
  logic signed [42:0] p3_s2;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      d1_s2 <= d1_s1;
      p6_s2 <= 43'(dt_s1) * 43'($signed({1'b0, coefs.c6}));
      p4_s2 <= 43'(dt_s1) * 43'($signed({1'b0, coefs.c4}));
      p3_s2 <= 43'(dt_s1) * 43'($signed({1'b0, coefs.c3}));
    end
  end

  // Stage 3: scale toward zero, form TEMP, OFF and SENS.
  logic signed [42:0] p6_b;
  logic signed [42:0] p4_b;
  logic signed [42:0] p3_b;
  logic        [35:0] off_frac;
  logic        [34:0] sens_frac;

  assign p6_b      = p6_s2 + (p6_s2[42] ? 43'sd8388607 : 43'sd0);
  assign p4_b      = p4_s2 + (p4_s2[42] ? 43'sd127 : 43'sd0);
  assign p3_b      = p3_s2 + (p3_s2[42] ? 43'sd255 : 43'sd0);
  assign off_frac  = p4_b[42:7];
  assign sens_frac = p3_b[42:8];

  logic        [23:0] d1_s3;
  logic signed [19:0] q_s3;
  logic signed [21:0] temp_s3;
  logic signed [47:0] off_s3;
  logic signed [47:0] sens_s3;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      d1_s3   <= d1_s2;
      q_s3    <= p6_b[42:23];
      temp_s3 <= $signed({{2{p6_b[42]}}, p6_b[42:23]}) + 22'sd2000;
      off_s3  <= $signed({16'b0, coefs.c2, 16'b0})
               + $signed({{12{off_frac[35]}}, off_frac});
      sens_s3 <= $signed({17'b0, coefs.c1, 15'b0})
               + $signed({{13{sens_frac[34]}}, sens_frac});
    end
  end

  // Stage 4: squares of the distances from 20 and -15 degrees.
  logic signed [20:0] b_w;
  logic signed [39:0] sq_full;
  logic signed [41:0] sq2_full;

  assign b_w      = $signed({q_s3[19], q_s3}) + 21'sd3500;
  assign sq_full  = 40'(q_s3) * 40'(q_s3);
  assign sq2_full = 42'(b_w) * 42'(b_w);

  logic        [23:0] d1_s4;
  logic signed [21:0] temp_s4;
  logic signed [47:0] off_s4;
  logic signed [47:0] sens_s4;
  logic        [38:0] sq_s4;
  logic        [40:0] sq2_s4;
  logic               neg_s4;
  logic               vcold_s4;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      d1_s4    <= d1_s3;
      temp_s4  <= temp_s3;
      off_s4   <= off_s3;
      sens_s4  <= sens_s3;
      sq_s4    <= sq_full[38:0];
      sq2_s4   <= sq2_full[40:0];
      neg_s4   <= q_s3[19];
      vcold_s4 <= q_s3 < -20'sd3500;
    end
  end

  // Stage 5: second-order corrections.
  logic [47:0] sq_w;
  logic [47:0] sq2_w;
  logic [47:0] five_sq;
  logic [47:0] seven_sq2;
  logic [47:0] eleven_sq2;
  logic [47:0] off2_w;
  logic [47:0] sens2_w;

  assign sq_w       = {9'b0, sq_s4};
  assign sq2_w      = {7'b0, sq2_s4};
  assign five_sq    = (sq_w << 2) + sq_w;
  assign seven_sq2  = (sq2_w << 3) - sq2_w;
  assign eleven_sq2 = (sq2_w << 3) + (sq2_w << 1) + sq2_w;

  always_comb begin
    off2_w  = '0;
    sens2_w = '0;
    if (neg_s4) begin
      off2_w  = (five_sq >> 1) + (vcold_s4 ? seven_sq2 : 48'd0);
      sens2_w = (five_sq >> 2) + (vcold_s4 ? (eleven_sq2 >> 1) : 48'd0);
    end
  end

  logic        [23:0] d1_s5;
  logic signed [21:0] temp_s5;
  logic signed [47:0] off_s5;
  logic signed [47:0] sens_s5;
  logic        [47:0] off2_s5;
  logic        [47:0] sens2_s5;
  logic               neg_s5;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      d1_s5    <= d1_s4;
      temp_s5  <= temp_s4;
      off_s5   <= off_s4;
      sens_s5  <= sens_s4;
      off2_s5  <= off2_w;
      sens2_s5 <= sens2_w;
      neg_s5   <= neg_s4;
    end
  end

  // Stage 6: corrected offset and sensitivity.
  logic        [23:0] d1_s6;
  logic signed [21:0] temp_s6;
  logic signed [47:0] offc_s6;
  logic signed [47:0] sensc_s6;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      d1_s6    <= d1_s5;
      temp_s6  <= temp_s5;
      offc_s6  <= off_s5 - $signed(off2_s5);
      sensc_s6 <= sens_s5 - $signed(sens2_s5);
    end
  end

  // Stage 7: D1 times SENS as two 24-bit partial products.
  logic signed [21:0] temp_s7;
  logic signed [47:0] offc_s7;
  logic        [47:0] lo_s7;
  logic signed [48:0] hi_s7;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      temp_s7 <= temp_s6;
      offc_s7 <= offc_s6;
      lo_s7   <= 48'(d1_s6) * 48'(sensc_s6[23:0]);
      hi_s7   <= 49'($signed({1'b0, d1_s6})) * 49'($signed(sensc_s6[47:24]));
    end
  end

  // Stage 8: combine partial products; the exact product fits 64 bits.
  logic signed [21:0] temp_s8;
  logic signed [47:0] offc_s8;
  logic signed [63:0] prod_s8;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      temp_s8 <= temp_s7;
      offc_s8 <= offc_s7;
      prod_s8 <= $signed({hi_s7[39:0], 24'b0}) + $signed({16'b0, lo_s7});
    end
  end

  // Stage 9: divide by 2^21 toward zero and remove the offset.
  logic signed [63:0] prod_b;

  assign prod_b = prod_s8 + (prod_s8[63] ? 64'sd2097151 : 64'sd0);

  logic signed [21:0] temp_s9;
  logic signed [47:0] x_s9;

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      temp_s9 <= temp_s8;
      x_s9    <= $signed({{5{prod_b[63]}}, prod_b[63:21]}) - offc_s8;
    end
  end

  // Stage 10: divide by 2^15 toward zero and saturate into the output register.
  logic signed [47:0] x_b;
  logic signed [32:0] pres_w;
  logic signed [31:0] pres_sat;

  assign x_b    = x_s9 + (x_s9[47] ? 48'sd32767 : 48'sd0);
  assign pres_w = x_b[47:15];

  always_comb begin
    if (pres_w[32] != pres_w[31]) begin
      pres_sat = pres_w[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      pres_sat = pres_w[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      result.pressure    <= pres_sat;
      result.temperature <= {{10{temp_s9[21]}}, temp_s9};
    end
  end

  // A completely full pipeline with a stalled output must refuse input.
  `BPC_ASSERT_IMM(a_full_stall, (&vld) && !result.ready, !sample.ready)
  // The very-cold branch is a subset of the low-temperature branch.
  `BPC_ASSERT_IMM(a_cold_is_low, vld[3] && vcold_s4, neg_s4)
  // At or above 20 degrees no correction is applied.
  `BPC_ASSERT_IMM(a_warm_no_corr, vld[4] && !neg_s5, off2_s5 == '0 && sens2_s5 == '0)
  // A held stage keeps its item.
  `BPC_ASSERT_NXT(a_hold_on_stall, vld[3] && !adv[3], vld[3] && $stable(sq_s4))

endmodule

[hdl/baro_pressure_compensation_top.sv]
// ----------------------------------------------------------------------------
// baro_pressure_compensation_top
// Pipeline: ten register stages; the last of them is the output register.
// Throughput: one sample pair per cycle while result is not stalled; the 64-bit
// D1 x SENS product is split into two 24-bit partial products over two stages.
// Reset: synchronous, clears all stage valid bits and calibration words to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Second-order barometric compensation. A sample transaction carries raw
// pressure D1 and raw temperature D2. The pipeline computes dT, the
// first-order temperature, offset and sensitivity, subtracts the low and
// very-cold temperature corrections, and forms the pressure in 0.01 mbar,
// saturated to 32 bits. All scaling divides truncate toward zero.
//
// Each stage holds its own valid bit and moves on whenever the stage ahead
// is empty or moving, so bubbles are squeezed out and a stalled result
// transaction only backs up the stages behind it.
//
// The calibration words live in an APB register file at byte offsets 0, 4,
// 8, 12, 16 and 20 for C1 through C6. They are meant to be written only
// while no sample transaction is in flight.

module baro_pressure_compensation_top (
  input  logic                       clk,
  input  logic                       rst,
  bpc_in_if.sink                     sample,
  bpc_out_if.source                  result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0] paddr,
  input  logic [bpc_pkg::DATA_W-1:0] pwdata,
  output logic [bpc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  bpc_pkg::coef_t coefs;

  // Calibration register file.
  bpc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coefs   (coefs)
  );

  // Arithmetic pipeline.
  bpc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .coefs  (coefs),
    .sample (sample),
    .result (result)
  );

endmodule

[verif/tb_baro_pressure_compensation_top.sv]
// ----------------------------------------------------------------------------
// tb_baro_pressure_compensation_top
// Self-checking bench for the second-order barometric compensation block. It
// loads several sets of calibration words over APB, streams raw D1/D2 sample
// transactions with random gaps and output backpressure, and compares every
// result transaction against a cycle-free model of the compensation math.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_baro_pressure_compensation_top;

  // Register indexes past C6. Writes there must leave the calibration alone.
  localparam logic [2:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;

  // Output stall that is long enough to fill all ten stages and back up the
  // sample channel while the sender keeps offering.
  localparam int LONG_HOLD   = 300;
  // Worst correct run is far below this; it only catches a hung pipeline.
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [23:0] d1;
    logic [23:0] d2;
  } raw_pair_t;

  typedef struct {
    logic signed [31:0] pressure;
    logic signed [31:0] temperature;
  } comp_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [bpc_pkg::ADDR_W-1:0] paddr;
  logic [bpc_pkg::DATA_W-1:0] pwdata;
  logic [bpc_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  bpc_in_if  sample_if ();
  bpc_out_if result_if ();

  baro_pressure_compensation_top u_top (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_if),
    .result  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk = ~clk;

  // Pairs waiting to be offered, and compensated values waiting to come out.
  raw_pair_t    pending_pairs[$];
  comp_result_t expected_comp[$];

  // Calibration words as the block should currently hold them.
  bpc_pkg::coef_t cal;

  // Per-phase traffic shaping, set by the sequencer at a falling edge only.
  bit send_gaps;
  bit recv_stalls;
  int hold_seq;

  int err_cnt;
  int sent_cnt;
  int recv_cnt;
  int wr_cnt;
  int cfg_cnt;
  int hold_cnt;
  int cycle_cnt;

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 2);
    end else if (r < 95) begin
      return $urandom_range(3, 8);
    end
    return $urandom_range(20, 40);
  endfunction

  // Compensation math in exact 64-bit signed arithmetic. SystemVerilog signed
  // division truncates toward zero, which is what the block must do.
  function automatic comp_result_t compensate(logic [23:0] d1_raw, logic [23:0] d2_raw);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, t, off, sens, off2, sens2, lo_sq, vc_sq, p;
    comp_result_t r;
    d1 = {40'd0, d1_raw};
    d2 = {40'd0, d2_raw};
    c1 = {48'd0, cal.c1};
    c2 = {48'd0, cal.c2};
    c3 = {48'd0, cal.c3};
    c4 = {48'd0, cal.c4};
    c5 = {48'd0, cal.c5};
    c6 = {48'd0, cal.c6};
    dt   = d2 - c5 * 256;
    t    = 2000 + (dt * c6) / 8388608;
    off  = c2 * 65536 + (c4 * dt) / 128;
    sens = c1 * 32768 + (c3 * dt) / 256;
    off2  = 0;
    sens2 = 0;
    // Corrections are rebuilt from scratch for every pair.
    if (t < 2000) begin
      lo_sq = (t - 2000) * (t - 2000);
      off2  = (5 * lo_sq) / 2;
      sens2 = (5 * lo_sq) / 4;
      if (t < -1500) begin
        vc_sq = (t + 1500) * (t + 1500);
        off2  = off2 + 7 * vc_sq;
        sens2 = sens2 + (11 * vc_sq) / 2;
      end
    end
    off  = off - off2;
    sens = sens - sens2;
    p = ((d1 * sens) / 2097152 - off) / 32768;
    if (p > 64'sd2147483647) begin
      p = 64'sd2147483647;
    end else if (p < -64'sd2147483648) begin
      p = -64'sd2147483648;
    end
    r.pressure    = p[31:0];
    r.temperature = t[31:0];
    return r;
  endfunction

  // Random pair: some at the field extremes, many with D2 near the reference
  // temperature so that all three temperature bands show up, the rest uniform.
  function automatic raw_pair_t random_pair();
    raw_pair_t s;
    int        sel;
    int        v;
    sel  = $urandom_range(0, 9);
    s.d1 = 24'($urandom);
    s.d2 = 24'($urandom);
    if (sel == 0) begin
      s.d1 = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
      s.d2 = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
    end else if (sel <= 4) begin
      v = int'(cal.c5) * 256 + int'($urandom_range(0, 2097152)) - 1048576;
      if (v < 0) begin
        v = 0;
      end else if (v > 24'hFFFFFF) begin
        v = 24'hFFFFFF;
      end
      s.d2 = v[23:0];
    end
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Sample driver. It offers the head of pending_pairs, holds it until the
  // block takes it, and predicts the result on the accepting edge, when the
  // calibration mirror matches what the block uses.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : sample_driver
    raw_pair_t taken;
    bit        fire;
    int        gap_left;
    if (rst) begin
      sample_if.valid           <= 1'b0;
      sample_if.raw_pressure    <= '0;
      sample_if.raw_temperature <= '0;
      gap_left = 0;
    end else begin
      fire = sample_if.valid && sample_if.ready;
      if (fire) begin
        taken = pending_pairs.pop_front();
        expected_comp.push_back(compensate(taken.d1, taken.d2));
        sent_cnt++;
        if (send_gaps && $urandom_range(0, 2) == 0) begin
          gap_left = gap_len();
        end
      end
      if (sample_if.valid && !fire) begin
        // Keep the offered transaction stable until it is taken.
      end else if (gap_left > 0) begin
        gap_left--;
        sample_if.valid <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        sample_if.valid           <= 1'b1;
        sample_if.raw_pressure    <= pending_pairs[0].d1;
        sample_if.raw_temperature <= pending_pairs[0].d2;
      end else begin
        sample_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. Checks each accepted result transaction against the oldest
  // prediction, and drives ready with random stalls. A change of hold_seq
  // starts one long stall that this process counts down by itself.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    comp_result_t want;
    int           stall_left;
    int           hold_left;
    int           hold_seen;
    if (rst) begin
      result_if.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
      hold_seen  = 0;
    end else begin
      if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
        if (expected_comp.size() == 0) begin
          $error("result transaction arrived with no prediction waiting");
          err_cnt++;
        end else begin
          want = expected_comp.pop_front();
          recv_cnt++;
          if (result_if.pressure !== want.pressure) begin
            $error("pressure mismatch: expected %0d, actual %0d",
                   want.pressure, result_if.pressure);
            err_cnt++;
          end
          if (result_if.temperature !== want.temperature) begin
            $error("temperature mismatch: expected %0d, actual %0d",
                   want.temperature, result_if.temperature);
            err_cnt++;
          end
        end
      end
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = LONG_HOLD;
        hold_cnt++;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
        if (recv_stalls && $urandom_range(0, 3) == 0) begin
          stall_left = gap_len();
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_cnt, expected_comp.size());
      $display("tb_baro_pressure_compensation_top NOT OK");
      $finish;
    end
  end

  // One APB write: setup cycle, then access cycle until pready. The mirror
  // follows only the low 16 bits and only for mapped registers.
  task automatic write_coef(logic [2:0] idx, logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    wr_cnt++;
    case (idx)
      bpc_pkg::REG_C1: cal.c1 = data[15:0];
      bpc_pkg::REG_C2: cal.c2 = data[15:0];
      bpc_pkg::REG_C3: cal.c3 = data[15:0];
      bpc_pkg::REG_C4: cal.c4 = data[15:0];
      bpc_pkg::REG_C5: cal.c5 = data[15:0];
      bpc_pkg::REG_C6: cal.c6 = data[15:0];
      default: ;
    endcase
  endtask

  // Loads all six words with junk in the unused upper bits, then pokes the
  // two unmapped indexes, which must change nothing.
  task automatic set_coefs(logic [15:0] c1, logic [15:0] c2, logic [15:0] c3,
                           logic [15:0] c4, logic [15:0] c5, logic [15:0] c6);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_coef(bpc_pkg::REG_C1, {junk, c1});
    junk = 16'($urandom);
    write_coef(bpc_pkg::REG_C2, {junk, c2});
    junk = 16'($urandom);
    write_coef(bpc_pkg::REG_C3, {junk, c3});
    junk = 16'($urandom);
    write_coef(bpc_pkg::REG_C4, {junk, c4});
    junk = 16'($urandom);
    write_coef(bpc_pkg::REG_C5, {junk, c5});
    junk = 16'($urandom);
    write_coef(bpc_pkg::REG_C6, {junk, c6});
    write_coef(REG_UNMAPPED_LO, $urandom);
    write_coef(REG_UNMAPPED_HI, $urandom);
    cfg_cnt++;
  endtask

  // Traffic knobs change on a falling edge so that the clocked processes
  // never race with them.
  task automatic start_phase(bit gaps, bit stalls, bit long_hold);
    @(negedge clk);
    send_gaps   = gaps;
    recv_stalls = stalls;
    if (long_hold) begin
      hold_seq++;
    end
  endtask

  // Sender stays quiet until every prediction has been matched, and the task then
  // waits on so the pipeline is empty before any register is touched.
  task automatic wait_drain();
    do @(negedge clk); while (pending_pairs.size() != 0 || expected_comp.size() != 0);
    repeat (bpc_pkg::STAGES + 4) @(negedge clk);
  endtask

  task automatic run_random(int n, bit gaps, bit stalls, bit long_hold);
    start_phase(gaps, stalls, long_hold);
    repeat (n) pending_pairs.push_back(random_pair());
    wait_drain();
  endtask

  task automatic queue_pair(logic [23:0] d1, logic [23:0] d2);
    pending_pairs.push_back({d1, d2});
  endtask

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  initial begin : sequencer
    int k;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    cal     = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Calibration still at its reset value of all zeros.
    run_random(40, 1'b0, 1'b0, 1'b0);

    // Directed pairs on typical calibration words. With C5 = 33464 the
    // reference D2 is 8566784 and C6 = 28312 sets where the bands start.
    set_coefs(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
    start_phase(1'b1, 1'b1, 1'b0);
    queue_pair(24'h000000, 24'h000000);
    queue_pair(24'hFFFFFF, 24'hFFFFFF);
    queue_pair(24'hFFFFFF, 24'h000000);
    queue_pair(24'h000000, 24'hFFFFFF);
    queue_pair(24'd9085466, 24'd8569150);   // typical room temperature
    queue_pair(24'd9085466, 24'd8566784);   // dT of zero, exactly 20.00 C
    queue_pair(24'd9085466, 24'd8566487);   // first step into the cold band
    queue_pair(24'd9085466, 24'd7974204);   // around 0 C
    queue_pair(24'd9085466, 24'd7529763);   // -15.00 C, not yet very cold
    queue_pair(24'd9085466, 24'd7529467);   // -15.01 C, very cold terms on
    // A very cold pair right before a warm one: no correction may linger.
    queue_pair(24'd9085466, 24'd0);
    queue_pair(24'd9085466, 24'd8569150);
    queue_pair(24'd7000000, 24'd7529467);
    queue_pair(24'd7000000, 24'd8600000);
    queue_pair(24'hFFFFFF, 24'd7529467);
    queue_pair(24'd1, 24'd7529763);
    queue_pair(24'h800000, 24'd8566487);
    queue_pair(24'hAAAAAA, 24'h555555);
    queue_pair(24'h555555, 24'hAAAAAA);
    queue_pair(24'h800000, 24'h7FFFFF);
    queue_pair(24'h7FFFFF, 24'h800000);
    wait_drain();

    // Same words, random traffic in two halves: the pipeline fully drains
    // between them while the sender waits.
    run_random(220, 1'b1, 1'b1, 1'b0);
    run_random(200, 1'b0, 1'b1, 1'b0);

    // Every word at its maximum, with a long output stall so the block fills.
    set_coefs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(220, 1'b0, 1'b0, 1'b1);

    // All words back to zero, written with junk in the upper bits.
    set_coefs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_random(60, 1'b1, 1'b0, 1'b0);

    // Maximum temperature slope with high reference: deep into the cold bands.
    set_coefs(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
    run_random(180, 1'b0, 1'b1, 1'b0);

    for (k = 0; k < 4; k++) begin
      set_coefs(16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom));
      run_random(180, k[0], k[1], 1'b0);
    end

    wait_drain();
    if (expected_comp.size() != 0) begin
      $error("%0d predicted results never arrived", expected_comp.size());
    end

    $display("Checked %0d of %0d sample transactions over %0d calibration sets",
             recv_cnt, sent_cnt, cfg_cnt);
    $display("(%0d APB writes). Long output stalls: %0d; cycles run: %0d; errors: %0d.",
             wr_cnt, hold_cnt, cycle_cnt, err_cnt);
    if (err_cnt == 0 && expected_comp.size() == 0) begin
      $display("tb_baro_pressure_compensation_top OK");
    end else begin
      $display("tb_baro_pressure_compensation_top NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/bpc_pkg.sv
hdl/bpc_in_if.sv
hdl/bpc_out_if.sv
hdl/bpc_regs.sv
hdl/bpc_core.sv
hdl/baro_pressure_compensation_top.sv
verif/tb_baro_pressure_compensation_top.sv
